### src/frwad_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// frwad_pkg
// Types and constants shared by the flow rate window anomaly detector.
// ============================================================================
package frwad_pkg;

    localparam int FLOWS    = 16;
    localparam int WINDOW   = 100;
    localparam int SLOT_W   = 4;
    localparam int CNT_W    = 7;
    localparam int WADDR_W  = $clog2(FLOWS * WINDOW);
    localparam int RATE_W   = 28;
    localparam int HOUR_W   = 5;
    localparam int SUM_W    = 35;
    localparam int SQS_W    = 63;
    localparam int D_W      = 70;
    localparam int EX_W     = 77;
    localparam int RAD_W    = 104;
    localparam int ROOT_W   = 52;
    localparam int REM_W    = 56;
    localparam int DVN_W    = 52;
    localparam int DVD_W    = 51;
    localparam int Q_W      = 17;
    localparam int STEP_W   = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [STEP_W-1:0] SQ_STEPS = STEP_W'(RAD_W / 2);
    localparam logic [STEP_W-1:0] DV_STEPS = STEP_W'(Q_W);

    localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [Q_W-1:0] Q16_0P7 = 17'd45875;
    localparam logic [Q_W-1:0] Q16_0P3 = 17'd19661;

    localparam logic [HOUR_W-1:0] EARLY_HOUR   = 5'd6;
    localparam logic [HOUR_W-1:0] LATE_HOUR    = 5'd22;
    localparam logic [HOUR_W-1:0] EVENING_HOUR = 5'd20;

    localparam logic [CNT_W-1:0] MIN_STAT_N  = 7'd2;
    localparam logic [CNT_W-1:0] MIN_VOLAT_N = 7'd3;
    localparam logic [CNT_W-1:0] MIN_EXFIL_N = 7'd5;
    localparam int CV_SCALE_D  = 100;
    localparam int CV_SCALE_SS = 49;

    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_ANALYZE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEV_FULL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_FULL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORK_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WORK_END  = 3'd5;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_EXFIL = 2'd1,
        KIND_VOLAT = 2'd2,
        KIND_OFFH  = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_S_LOOK,
        ST_S_STAT,
        ST_S_OLD,
        ST_S_WR,
        ST_A_RD,
        ST_A_LAT,
        ST_A_MUL1,
        ST_A_MUL2,
        ST_A_DIFF,
        ST_A_CMP,
        ST_A_SQ1,
        ST_A_DV1,
        ST_A_EX,
        ST_A_HI,
        ST_A_DV2,
        ST_A_DV3,
        ST_A_VO,
        ST_A_SQ2,
        ST_A_VS,
        ST_A_OFF,
        ST_A_NEXT,
        ST_A_END
    } t_state;

    typedef struct packed {
        logic                command;
        logic [31:0]         src_addr;
        logic [31:0]         dst_addr;
        logic [15:0]         src_port;
        logic [15:0]         dst_port;
        logic [7:0]          protocol;
        logic [RATE_W-1:0]   bytes_rate;
        logic [HOUR_W-1:0]   hour_of_day;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0]   flow_slot;
        t_kind               anomaly_kind;
        logic [Q_W-1:0]      confidence;
        logic [Q_W-1:0]      severity;
        logic                last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]    cnt;
        logic [CNT_W-1:0]    wpos;
        logic [SUM_W-1:0]    sum;
        logic [SQS_W-1:0]    sqs;
    } t_stat;

    localparam int STAT_W = $bits(t_stat);

endpackage

### src/frwad_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// frwad_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module frwad_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### src/flow_rate_window_anomaly_detector.sv
`timescale 1ns / 1ps
// ============================================================================
// flow_rate_window_anomaly_detector
// Flow table with per-flow rate windows and a batch anomaly analysis.
// ============================================================================
// Usage:
//   Drive a word on i_item and raise start; it is taken at a clock edge where
//   start is high and busy is low. Command 0 adds a rate sample to its flow,
//   command 1 walks all flows and reports anomalies.
//   Results appear on o_result for one cycle each, marked by o_result_valid;
//   the receiver cannot stall them. The final result of a run has last set;
//   a run with no anomaly gives one none result.
//   A sample that finds a slot keeps busy high through the lookup, statistics
//   read, old-sample read and write states, the read-modify-write of the
//   statistics RAM and the window RAM; no new word is taken until it ends.
//   An analyze run visits every slot; a used slot with n samples may run a
//   bit-serial square root (52 steps), a shift-subtract divider (17 steps) and
//   window scans at one sample per cycle. Results trail the work by one stage.
//   Reset empties the flow table at once and loads the register defaults. The user
//   must write registers through i_cfg_we only while the block is idle; the block does not enforce this.
// ============================================================================
module flow_rate_window_anomaly_detector (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  frwad_pkg::t_item                   i_item,
    output logic                               o_result_valid,
    output frwad_pkg::t_result                 o_result,
    input  logic                               i_cfg_we,
    input  logic [frwad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [frwad_pkg::RATE_W-1:0]       i_cfg_data
);
    import frwad_pkg::*;

    // configuration
    logic [RATE_W-1:0] r_hi_thr, r_off_thr, r_sev_full, r_conf_full;
    logic [HOUR_W-1:0] r_work_start, r_work_end;

    // flow table
    logic [FLOWS-1:0]  r_valid, n_valid;
    logic [63:0]       r_taddr [FLOWS];
    logic [39:0]       r_tppp  [FLOWS];
    logic              tbl_we;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_ok, n_ok, r_new, n_new;
    logic [63:0]       r_kaddr, n_kaddr;
    logic [39:0]       r_kppp, n_kppp;
    logic [RATE_W-1:0] r_rate, n_rate;
    logic [WADDR_W-1:0] r_base, n_base;
    logic [CNT_W-1:0]  r_n, n_n, r_wpos, n_wpos, r_i, n_i, r_high, n_high;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SQS_W-1:0]  r_q, n_q;
    logic              r_full, n_full;
    logic [RATE_W-1:0] r_old, n_old;
    logic [2*RATE_W-1:0] r_osq, n_osq, r_rsq, n_rsq;
    logic              r_off, n_off;
    logic [Q_W-1:0]    r_tconf, n_tconf;
    logic [D_W-1:0]    r_nq, n_nq, r_ss, n_ss, r_d, n_d;
    logic [EX_W-1:0]   r_ss49, n_ss49;
    logic [63:0]       r_pll, n_pll;
    logic [SUM_W-1:0]  r_plh, n_plh;
    logic [5:0]        r_phh, n_phh;
    logic [SUM_W-1:0]  r_thn, n_thn, r_offn, n_offn, r_dc, n_dc, r_ds, n_ds;
    logic              r_cgt, n_cgt, r_exc, n_exc, r_hit, n_hit;
    logic [Q_W-1:0]    r_cvq, n_cvq, r_vol, n_vol;
    logic [ROOT_W-1:0] r_r9, n_r9;
    logic              r_rv1, n_rv1, r_rv2, n_rv2;
    logic [SUM_W-1:0]  r_nx, n_nx;

    // shared square root and divider
    logic [RAD_W-1:0]  r_sq_t, n_sq_t;
    logic [REM_W-1:0]  r_sq_rem, n_sq_rem;
    logic [ROOT_W-1:0] r_sq_root, n_sq_root;
    logic [DVN_W-1:0]  r_dv_rem, n_dv_rem;
    logic [DVD_W-1:0]  r_dv_dsh, n_dv_dsh;
    logic [Q_W-1:0]    r_dv_q, n_dv_q;
    logic              r_dv_sat, n_dv_sat;
    logic [STEP_W-1:0] r_cnt, n_cnt;

    t_result           r_pend, n_pend, r_out, n_out;
    logic              r_pend_v, n_pend_v, r_out_v, n_out_v;

    // RAM ports
    logic              stat_we, win_we;
    t_stat             stat_wdata, stat_rd;
    logic [STAT_W-1:0] stat_rdata;
    logic [WADDR_W-1:0] win_raddr, win_waddr;
    logic [RATE_W-1:0] win_rdata;

    // combinational helpers
    logic              sq_load, sq_step, dv_load, dv_step, push_v;
    logic [RAD_W-1:0]  sq_rad;
    logic [DVN_W-1:0]  dv_num;
    logic [SUM_W-1:0]  dv_den;
    t_result           push_item;
    logic [REM_W-1:0]  sq_rem2, sq_trial;
    logic [Q_W-1:0]    dv_res;
    logic [RATE_W-1:0] conf_full1, sev_full1;
    logic              found, free_found;
    logic [SLOT_W-1:0] found_slot, free_slot;
    logic [63:0]       in_addr;
    logic [39:0]       in_ppp;
    t_stat             st;
    logic [SUM_W-1:0]  df;
    logic [Q_W:0]      exf_sum;

    frwad_ram #(.WIDTH(STAT_W), .DEPTH(FLOWS)) u_stat_ram (
        .i_clk  (i_clk),
        .i_we   (stat_we),
        .i_waddr(r_slot),
        .i_wdata(stat_wdata),
        .i_raddr(r_slot),
        .o_rdata(stat_rdata)
    );

    frwad_ram #(.WIDTH(RATE_W), .DEPTH(FLOWS * WINDOW)) u_win_ram (
        .i_clk  (i_clk),
        .i_we   (win_we),
        .i_waddr(win_waddr),
        .i_wdata(r_rate),
        .i_raddr(win_raddr),
        .o_rdata(win_rdata)
    );

    assign stat_rd    = t_stat'(stat_rdata);
    assign win_waddr  = r_base + WADDR_W'(r_wpos);
    assign conf_full1 = (r_conf_full == '0) ? RATE_W'(1) : r_conf_full;
    assign sev_full1  = (r_sev_full == '0) ? RATE_W'(1) : r_sev_full;
    assign in_addr    = {i_item.src_addr, i_item.dst_addr};
    assign in_ppp     = {i_item.src_port, i_item.dst_port, i_item.protocol};
    assign dv_res     = (r_dv_sat || r_dv_q > ONE_Q16) ? ONE_Q16 : r_dv_q;
    assign sq_rem2    = {r_sq_rem[REM_W-3:0], r_sq_t[RAD_W-1 -: 2]};
    assign sq_trial   = REM_W'({r_sq_root, 2'b01});
    assign df         = (r_nx >= r_sum) ? (r_nx - r_sum) : (r_sum - r_nx);
    assign exf_sum    = {1'b0, r_vol} + {1'b0, ONE_Q16} - {1'b0, r_cvq};

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_out_v;
    assign o_result       = r_out;

    // flow lookup: first matching slot, else first free slot
    always_comb begin
        found      = 1'b0;
        free_found = 1'b0;
        found_slot = '0;
        free_slot  = '0;
        for (int i = 0; i < FLOWS; i++) begin
            if (!found && r_valid[i] && r_taddr[i] == in_addr && r_tppp[i] == in_ppp) begin
                found      = 1'b1;
                found_slot = SLOT_W'(i);
            end
            if (!free_found && !r_valid[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;   n_slot = r_slot;   n_ok = r_ok;     n_new = r_new;
        n_kaddr = r_kaddr;   n_kppp = r_kppp;   n_rate = r_rate; n_base = r_base;
        n_n = r_n;           n_wpos = r_wpos;   n_i = r_i;       n_high = r_high;
        n_sum = r_sum;       n_q = r_q;         n_full = r_full; n_old = r_old;
        n_osq = r_osq;       n_rsq = r_rsq;     n_off = r_off;   n_tconf = r_tconf;
        n_nq = r_nq;         n_ss = r_ss;       n_d = r_d;       n_ss49 = r_ss49;
        n_pll = r_pll;       n_plh = r_plh;     n_phh = r_phh;   n_thn = r_thn;
        n_offn = r_offn;     n_dc = r_dc;       n_ds = r_ds;
        n_cgt = r_cgt;       n_exc = r_exc;     n_hit = r_hit;   n_cvq = r_cvq;
        n_vol = r_vol;       n_r9 = r_r9;       n_rv1 = 1'b0;    n_rv2 = 1'b0;
        n_nx = r_nx;
        n_sq_t = r_sq_t;     n_sq_rem = r_sq_rem; n_sq_root = r_sq_root;
        n_dv_rem = r_dv_rem; n_dv_dsh = r_dv_dsh; n_dv_q = r_dv_q; n_dv_sat = r_dv_sat;
        n_cnt = r_cnt;
        n_pend = r_pend;     n_pend_v = r_pend_v; n_out = r_out; n_out_v = 1'b0;
        n_valid = r_valid;
        stat_we = 1'b0;      win_we = 1'b0;     tbl_we = 1'b0;
        win_raddr = r_base + WADDR_W'(r_i);
        stat_wdata = '0;
        st = '0;
        sq_load = 1'b0; sq_step = 1'b0; sq_rad = '0;
        dv_load = 1'b0; dv_step = 1'b0; dv_num = '0; dv_den = '0;
        push_v = 1'b0;  push_item = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_item.command == CMD_SAMPLE) begin
                        n_ok    = found || free_found;
                        n_new   = !found;
                        n_slot  = found ? found_slot : free_slot;
                        n_kaddr = in_addr;
                        n_kppp  = in_ppp;
                        n_rate  = i_item.bytes_rate;
                        n_state = ST_S_LOOK;
                    end else begin
                        n_slot  = '0;
                        n_off   = (i_item.hour_of_day < r_work_start) ||
                                  (i_item.hour_of_day > r_work_end);
                        if (i_item.hour_of_day < EARLY_HOUR || i_item.hour_of_day > LATE_HOUR)
                        begin
                            n_tconf = ONE_Q16;
                        end else if (i_item.hour_of_day < r_work_start ||
                                     i_item.hour_of_day > EVENING_HOUR) begin
                            n_tconf = Q16_0P7;
                        end else begin
                            n_tconf = Q16_0P3;
                        end
                        n_state = ST_A_RD;
                    end
                end
            end
            ST_S_LOOK: begin
                n_base  = WADDR_W'(r_slot) * WADDR_W'(WINDOW);
                n_rsq   = (2*RATE_W)'(r_rate) * (2*RATE_W)'(r_rate);
                n_state = r_ok ? ST_S_STAT : ST_IDLE;
            end
            ST_S_STAT: begin
                st        = r_new ? t_stat'('0) : stat_rd;
                n_n       = st.cnt;
                n_wpos    = st.wpos;
                n_sum     = st.sum;
                n_q       = st.sqs;
                n_full    = (st.cnt >= CNT_W'(WINDOW));
                win_raddr = r_base + WADDR_W'(st.wpos);
                n_state   = ST_S_OLD;
            end
            ST_S_OLD: begin
                n_old   = r_full ? win_rdata : '0;
                n_osq   = r_full ? (2*RATE_W)'(win_rdata) * (2*RATE_W)'(win_rdata) : '0;
                n_state = ST_S_WR;
            end
            ST_S_WR: begin
                stat_wdata.cnt  = r_full ? r_n : r_n + CNT_W'(1);
                stat_wdata.wpos = (r_wpos + CNT_W'(1) >= CNT_W'(WINDOW)) ? '0
                                                                         : r_wpos + CNT_W'(1);
                stat_wdata.sum  = r_sum - SUM_W'(r_old) + SUM_W'(r_rate);
                stat_wdata.sqs  = r_q - SQS_W'(r_osq) + SQS_W'(r_rsq);
                stat_we = 1'b1;
                win_we  = 1'b1;
                if (r_new) begin
                    tbl_we          = 1'b1;
                    n_valid[r_slot] = 1'b1;
                end
                n_state = ST_IDLE;
            end
            ST_A_RD: begin
                n_base  = WADDR_W'(r_slot) * WADDR_W'(WINDOW);
                n_state = r_valid[r_slot] ? ST_A_LAT : ST_A_NEXT;
            end
            ST_A_LAT: begin
                n_n   = stat_rd.cnt;
                n_sum = stat_rd.sum;
                n_q   = stat_rd.sqs;
                if (stat_rd.cnt < MIN_STAT_N || stat_rd.sum == '0) begin
                    n_state = ST_A_NEXT;
                end else begin
                    n_state = ST_A_MUL1;
                end
            end
            ST_A_MUL1: begin
                n_nq   = D_W'(r_n) * D_W'(r_q);
                n_pll  = 64'(r_sum[31:0]) * 64'(r_sum[31:0]);
                n_plh  = SUM_W'(r_sum[SUM_W-1:32]) * SUM_W'(r_sum[31:0]);
                n_phh  = 6'(r_sum[SUM_W-1:32]) * 6'(r_sum[SUM_W-1:32]);
                n_thn  = SUM_W'(r_n) * SUM_W'(r_hi_thr);
                n_offn = SUM_W'(r_n) * SUM_W'(r_off_thr);
                n_state = ST_A_MUL2;
            end
            ST_A_MUL2: begin
                n_ss = D_W'(r_pll) + (D_W'(r_plh) << 33) + (D_W'(r_phh) << 64);
                n_dc = SUM_W'(r_n) * SUM_W'(conf_full1);
                n_ds = SUM_W'(r_n) * SUM_W'(sev_full1);
                n_state = ST_A_DIFF;
            end
            ST_A_DIFF: begin
                n_d    = r_nq - r_ss;
                n_ss49 = EX_W'(r_ss) * EX_W'(CV_SCALE_SS);
                n_state = ST_A_CMP;
            end
            ST_A_CMP: begin
                n_cgt = (r_d > r_ss);
                n_exc = (r_n >= MIN_EXFIL_N) && (r_sum > r_thn) &&
                        (EX_W'(r_d) * EX_W'(CV_SCALE_D) < r_ss49);
                if (r_d >= r_ss) begin
                    n_cvq   = ONE_Q16;
                    n_state = ST_A_EX;
                end else begin
                    sq_load = 1'b1;
                    sq_rad  = RAD_W'({r_d, 32'b0});
                    n_state = ST_A_SQ1;
                end
            end
            ST_A_SQ1: begin
                if (r_cnt != '0) begin
                    sq_step = 1'b1;
                end else begin
                    dv_load = 1'b1;
                    dv_num  = r_sq_root;
                    dv_den  = r_sum;
                    n_state = ST_A_DV1;
                end
            end
            ST_A_DV1: begin
                if (r_cnt != '0) begin
                    dv_step = 1'b1;
                end else begin
                    n_cvq   = dv_res;
                    n_state = ST_A_EX;
                end
            end
            ST_A_EX: begin
                n_i    = '0;
                n_high = '0;
                n_state = r_exc ? ST_A_HI : ST_A_VO;
            end
            ST_A_HI: begin
                // one read issued per cycle, data compared in the next cycle
                if (r_i < r_n) begin
                    n_i   = r_i + CNT_W'(1);
                    n_rv1 = 1'b1;
                end
                if (r_rv1 && win_rdata > r_hi_thr) begin
                    n_high = r_high + CNT_W'(1);
                end
                if (r_i == r_n && !r_rv1) begin
                    if ({r_high, 1'b0} > {1'b0, r_n}) begin
                        dv_load = 1'b1;
                        dv_num  = DVN_W'({r_sum, 16'b0});
                        dv_den  = r_dc;
                        n_state = ST_A_DV2;
                    end else begin
                        n_state = ST_A_VO;
                    end
                end
            end
            ST_A_DV2: begin
                if (r_cnt != '0) begin
                    dv_step = 1'b1;
                end else begin
                    n_vol   = dv_res;
                    dv_load = 1'b1;
                    dv_num  = DVN_W'({r_sum, 16'b0});
                    dv_den  = r_ds;
                    n_state = ST_A_DV3;
                end
            end
            ST_A_DV3: begin
                if (r_cnt != '0) begin
                    dv_step = 1'b1;
                end else begin
                    push_v                 = 1'b1;
                    push_item.flow_slot    = r_slot;
                    push_item.anomaly_kind = KIND_EXFIL;
                    push_item.confidence   = exf_sum[Q_W:1];
                    push_item.severity     = dv_res;
                    n_state = ST_A_VO;
                end
            end
            ST_A_VO: begin
                if (r_n < MIN_VOLAT_N) begin
                    n_state = ST_A_OFF;
                end else if (r_cgt) begin
                    push_v                 = 1'b1;
                    push_item.flow_slot    = r_slot;
                    push_item.anomaly_kind = KIND_VOLAT;
                    push_item.confidence   = r_cvq;
                    push_item.severity     = r_cvq;
                    n_state = ST_A_OFF;
                end else begin
                    sq_load = 1'b1;
                    sq_rad  = RAD_W'((D_W + 4)'(r_d) * (D_W + 4)'(9));
                    n_state = ST_A_SQ2;
                end
            end
            ST_A_SQ2: begin
                if (r_cnt != '0) begin
                    sq_step = 1'b1;
                end else begin
                    n_r9    = r_sq_root;
                    n_i     = '0;
                    n_hit   = 1'b0;
                    n_state = ST_A_VS;
                end
            end
            ST_A_VS: begin
                // read, scale by n, then compare the distance to the 3-sigma bound
                if (r_i < r_n) begin
                    n_i   = r_i + CNT_W'(1);
                    n_rv1 = 1'b1;
                end
                if (r_rv1) begin
                    n_nx  = SUM_W'(r_n) * SUM_W'(win_rdata);
                    n_rv2 = 1'b1;
                end
                if (r_rv2 && ROOT_W'(df) > r_r9) begin
                    n_hit = 1'b1;
                end
                if (r_i == r_n && !r_rv1 && !r_rv2) begin
                    if (r_hit) begin
                        push_v                 = 1'b1;
                        push_item.flow_slot    = r_slot;
                        push_item.anomaly_kind = KIND_VOLAT;
                        push_item.confidence   = r_cvq;
                        push_item.severity     = r_cvq;
                    end
                    n_state = ST_A_OFF;
                end
            end
            ST_A_OFF: begin
                if (r_off && r_sum > r_offn) begin
                    push_v                 = 1'b1;
                    push_item.flow_slot    = r_slot;
                    push_item.anomaly_kind = KIND_OFFH;
                    push_item.confidence   = r_tconf;
                    push_item.severity     = Q16_0P7;
                end
                n_state = ST_A_NEXT;
            end
            ST_A_NEXT: begin
                if (r_slot == SLOT_W'(FLOWS - 1)) begin
                    n_state = ST_A_END;
                end else begin
                    n_slot  = r_slot + SLOT_W'(1);
                    n_state = ST_A_RD;
                end
            end
            ST_A_END: begin
                // flush the held word as the last one, or report none
                n_out_v = 1'b1;
                if (r_pend_v) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                end else begin
                    n_out              = '0;
                    n_out.anomaly_kind = KIND_NONE;
                    n_out.last         = 1'b1;
                end
                n_pend_v = 1'b0;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        // hold one result back so the final one can carry last
        if (push_v) begin
            n_out_v  = r_pend_v;
            n_out    = r_pend;
            n_out.last = 1'b0;
            n_pend   = push_item;
            n_pend_v = 1'b1;
        end

        if (sq_load) begin
            n_sq_t    = sq_rad;
            n_sq_rem  = '0;
            n_sq_root = '0;
            n_cnt     = SQ_STEPS;
        end else if (sq_step) begin
            n_sq_t = {r_sq_t[RAD_W-3:0], 2'b00};
            if (sq_rem2 >= sq_trial) begin
                n_sq_rem  = sq_rem2 - sq_trial;
                n_sq_root = {r_sq_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_sq_rem  = sq_rem2;
                n_sq_root = {r_sq_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - STEP_W'(1);
        end

        if (dv_load) begin
            n_dv_rem = dv_num;
            n_dv_dsh = DVD_W'({dv_den, 16'b0});
            n_dv_sat = (dv_num >= DVN_W'({dv_den, 17'b0}));
            n_dv_q   = '0;
            n_cnt    = DV_STEPS;
        end else if (dv_step) begin
            if (DVN_W'(r_dv_dsh) <= r_dv_rem) begin
                n_dv_rem = r_dv_rem - DVN_W'(r_dv_dsh);
                n_dv_q   = {r_dv_q[Q_W-2:0], 1'b1};
            end else begin
                n_dv_q   = {r_dv_q[Q_W-2:0], 1'b0};
            end
            n_dv_dsh = r_dv_dsh >> 1;
            n_cnt    = r_cnt - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
            r_hi_thr     <= RATE_W'(5242880);
            r_off_thr    <= RATE_W'(2097152);
            r_sev_full   <= RATE_W'(10485760);
            r_conf_full  <= RATE_W'(20971520);
            r_work_start <= HOUR_W'(8);
            r_work_end   <= HOUR_W'(18);
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HIGH_THR:   r_hi_thr     <= i_cfg_data;
                    CFG_OFF_THR:    r_off_thr    <= i_cfg_data;
                    CFG_SEV_FULL:   r_sev_full   <= i_cfg_data;
                    CFG_CONF_FULL:  r_conf_full  <= i_cfg_data;
                    CFG_WORK_START: r_work_start <= i_cfg_data[HOUR_W-1:0];
                    CFG_WORK_END:   r_work_end   <= i_cfg_data[HOUR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_taddr[r_slot] <= r_kaddr;
            r_tppp[r_slot]  <= r_kppp;
        end
        r_slot <= n_slot;   r_ok <= n_ok;       r_new <= n_new;     r_kaddr <= n_kaddr;
        r_kppp <= n_kppp;   r_rate <= n_rate;   r_base <= n_base;   r_n <= n_n;
        r_wpos <= n_wpos;   r_i <= n_i;         r_high <= n_high;   r_sum <= n_sum;
        r_q <= n_q;         r_full <= n_full;   r_old <= n_old;     r_osq <= n_osq;
        r_rsq <= n_rsq;     r_off <= n_off;     r_tconf <= n_tconf; r_nq <= n_nq;
        r_ss <= n_ss;       r_d <= n_d;         r_ss49 <= n_ss49;   r_pll <= n_pll;
        r_plh <= n_plh;     r_phh <= n_phh;     r_thn <= n_thn;     r_offn <= n_offn;
        r_dc <= n_dc;       r_ds <= n_ds;       r_cgt <= n_cgt;
        r_exc <= n_exc;     r_hit <= n_hit;     r_cvq <= n_cvq;     r_vol <= n_vol;
        r_r9 <= n_r9;       r_rv1 <= n_rv1;     r_rv2 <= n_rv2;     r_nx <= n_nx;
        r_sq_t <= n_sq_t;   r_sq_rem <= n_sq_rem; r_sq_root <= n_sq_root;
        r_dv_rem <= n_dv_rem; r_dv_dsh <= n_dv_dsh; r_dv_q <= n_dv_q;
        r_dv_sat <= n_dv_sat; r_cnt <= n_cnt;
        r_pend <= n_pend;   r_out <= n_out;
    end

`ifndef SYNTHESIS
    // the end of a run always produces the closing word next cycle
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_A_END |=> o_result_valid && o_result.last)
        else $error("analyze run ended without a last word");

    // nothing follows the last word of a run in the next cycle
    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.last |=> !o_result_valid)
        else $error("word right after last");

    // a none word is only ever the closing word
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.anomaly_kind == KIND_NONE |-> o_result.last)
        else $error("none word not marked last");

    // cv quotient stays below one since the deviation term is below the square sum
    a_cv_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_A_DV1 && r_cnt == '0 |-> !r_dv_sat && r_dv_q < ONE_Q16)
        else $error("cv quotient overflow");

    // window writes happen only for a sample that found a slot
    a_win_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_we |-> r_ok && $past(r_state) == ST_S_OLD)
        else $error("window write outside sample update");
`endif

endmodule

### dv/tb_flow_rate_window_anomaly_detector.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_flow_rate_window_anomaly_detector
// Self-checking bench for the flow rate window anomaly detector.
// ----------------------------------------------------------------------------
// A clocked driver feeds sample and analyze words from a queue. A clocked
// monitor scores every accepted word against a local flow table model and
// compares each result strobe, field by field, with the oldest predicted
// anomaly. Three phases run with different register settings and sender
// idle rates. Directed words cover the empty table, extreme tuples and rates,
// and hour edges. Random traffic then fills the table past its limit and
// mixes steady, bursty, moderate and idle flows.
// ============================================================================
module tb_flow_rate_window_anomaly_detector;
    import frwad_pkg::*;

    localparam int  POOL      = 20;
    localparam int  MAX_CYC   = 4000000;
    localparam int  PHASE_N   = 135;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_result_valid;
    t_result o_result;
    logic    i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [RATE_W-1:0]    i_cfg_data;

    flow_rate_window_anomaly_detector dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // model registers
    logic [RATE_W-1:0] m_high_thr, m_off_thr, m_sev_full, m_conf_full;
    logic [HOUR_W-1:0] m_work_start, m_work_end;

    // model flow table
    logic               tbl_valid [FLOWS];
    logic [63:0]        tbl_addr  [FLOWS];
    logic [39:0]        tbl_ppp   [FLOWS];
    longint unsigned    tbl_win   [FLOWS][WINDOW];
    longint unsigned    tbl_cnt   [FLOWS];
    longint unsigned    tbl_wpos  [FLOWS];
    longint unsigned    tbl_sum   [FLOWS];
    longint unsigned    tbl_sqs   [FLOWS];

    t_item   item_q    [$];
    t_result anomaly_q [$];
    t_item   pool_t    [POOL];

    int idle_pct;
    int errors;
    int cycles;
    int n_words, n_analyze, n_results;
    int kind_seen [4];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned q16_ratio(longint unsigned s, longint unsigned n,
                                                  logic [RATE_W-1:0] full);
        longint unsigned den, q;
        den = n * ((full == '0) ? 64'd1 : 64'(full));
        q = (s << 16) / den;
        return (q > 65536) ? 64'd65536 : q;
    endfunction

    // append a word to the driver queue
    task automatic queue_word(t_item it);
        item_q.insert(item_q.size(), it);
    endtask

    task automatic flow_sample(t_item it);
        logic [63:0] a;
        logic [39:0] p;
        longint unsigned r, old;
        int s, pos;
        a = {it.src_addr, it.dst_addr};
        p = {it.src_port, it.dst_port, it.protocol};
        r = it.bytes_rate;
        s = -1;
        for (int i = 0; i < FLOWS; i++)
            if (tbl_valid[i] && tbl_addr[i] == a && tbl_ppp[i] == p) begin
                s = i;
                break;
            end
        if (s < 0) begin
            for (int i = 0; i < FLOWS; i++)
                if (!tbl_valid[i]) begin
                    s = i;
                    break;
                end
            // drop: table full
            if (s < 0) return;
            tbl_valid[s] = 1'b1;
            tbl_addr[s]  = a;
            tbl_ppp[s]   = p;
            tbl_cnt[s]   = 0;
            tbl_wpos[s]  = 0;
            tbl_sum[s]   = 0;
            tbl_sqs[s]   = 0;
        end
        pos = int'(tbl_wpos[s]);
        if (tbl_cnt[s] >= WINDOW) begin
            old = tbl_win[s][pos];
            tbl_sum[s] -= old;
            tbl_sqs[s] -= old * old;
        end else begin
            tbl_cnt[s]++;
        end
        tbl_win[s][pos] = r;
        tbl_sum[s] += r;
        tbl_sqs[s] += r * r;
        tbl_wpos[s] = (pos + 1 >= WINDOW) ? 0 : pos + 1;
    endtask

    task automatic analyze_flows(logic [HOUR_W-1:0] hour);
        t_result run_q [$];
        t_result e;
        logic [127:0] nw, sw, ss, dd, t, qs, df, nx;
        longint unsigned cvq, hi_cnt, vol, lo, hi, mid, tconf;
        logic off, hit;
        off = (hour < m_work_start) || (hour > m_work_end);
        tconf = (hour < EARLY_HOUR || hour > LATE_HOUR) ? 65536 :
                ((hour < m_work_start || hour > EVENING_HOUR) ? 45875 : 19661);
        for (int s = 0; s < FLOWS; s++) begin
            if (!tbl_valid[s] || tbl_cnt[s] < 2 || tbl_sum[s] == 0) continue;
            nw = tbl_cnt[s];
            sw = tbl_sum[s];
            ss = sw * sw;
            dd = nw * 128'(tbl_sqs[s]) - ss;
            if (dd >= ss) begin
                cvq = 65536;
            end else begin
                t = dd << 32;
                lo = 0;
                hi = 65535;
                while (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    qs = 128'(mid) * sw;
                    if (qs * qs <= t) lo = mid; else hi = mid - 1;
                end
                cvq = lo;
            end
            e.flow_slot = SLOT_W'(s);
            e.last      = 1'b0;
            if (tbl_cnt[s] >= 5 && tbl_sum[s] > 64'(m_high_thr) * tbl_cnt[s] &&
                dd * 100 < ss * 49) begin
                hi_cnt = 0;
                for (int i = 0; i < tbl_cnt[s]; i++)
                    if (tbl_win[s][i] > m_high_thr) hi_cnt++;
                if (2 * hi_cnt > tbl_cnt[s]) begin
                    vol = q16_ratio(tbl_sum[s], tbl_cnt[s], m_conf_full);
                    e.anomaly_kind = KIND_EXFIL;
                    e.confidence   = Q_W'((vol + 65536 - cvq) >> 1);
                    e.severity     = Q_W'(q16_ratio(tbl_sum[s], tbl_cnt[s], m_sev_full));
                    run_q.insert(run_q.size(), e);
                end
            end
            if (tbl_cnt[s] >= 3) begin
                hit = (dd > ss);
                for (int i = 0; i < tbl_cnt[s] && !hit; i++) begin
                    nx = nw * 128'(tbl_win[s][i]);
                    df = (nx > sw) ? nx - sw : sw - nx;
                    if (df * df > dd * 9) hit = 1'b1;
                end
                if (hit) begin
                    e.anomaly_kind = KIND_VOLAT;
                    e.confidence   = Q_W'(cvq);
                    e.severity     = Q_W'(cvq);
                    run_q.insert(run_q.size(), e);
                end
            end
            if (off && tbl_sum[s] > 64'(m_off_thr) * tbl_cnt[s]) begin
                e.anomaly_kind = KIND_OFFH;
                e.confidence   = Q_W'(tconf);
                e.severity     = Q16_0P7;
                run_q.insert(run_q.size(), e);
            end
        end
        if (run_q.size() == 0) begin
            e = '0;
            e.anomaly_kind = KIND_NONE;
            run_q.insert(run_q.size(), e);
        end
        run_q[run_q.size()-1].last = 1'b1;
        foreach (run_q[i]) anomaly_q.insert(anomaly_q.size(), run_q[i]);
    endtask

    // driver: hold the word until taken, then load the next or drop start
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (item_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_item <= item_q.pop_front();
                start  <= 1'b1;
            end else begin
                start  <= 1'b0;
            end
        end
    end

    // monitor: score results, then predict on accepted words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) begin
                n_results++;
                kind_seen[o_result.anomaly_kind]++;
                if (anomaly_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected result slot=%0d kind=%0d conf=%0d sev=%0d",
                                 o_result.flow_slot, o_result.anomaly_kind,
                                 o_result.confidence, o_result.severity);
                end else begin
                    if (o_result.flow_slot !== anomaly_q[0].flow_slot ||
                        o_result.anomaly_kind !== anomaly_q[0].anomaly_kind ||
                        o_result.confidence !== anomaly_q[0].confidence ||
                        o_result.severity !== anomaly_q[0].severity ||
                        o_result.last !== anomaly_q[0].last) begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: exp slot=%0d kind=%0d conf=%0d sev=%0d last=%0d / %s",
                                     anomaly_q[0].flow_slot, anomaly_q[0].anomaly_kind,
                                     anomaly_q[0].confidence, anomaly_q[0].severity,
                                     anomaly_q[0].last,
                                     $sformatf("got slot=%0d kind=%0d conf=%0d sev=%0d last=%0d",
                                               o_result.flow_slot, o_result.anomaly_kind,
                                               o_result.confidence, o_result.severity,
                                               o_result.last));
                    end
                    void'(anomaly_q.pop_front());
                end
            end
            if (start && !busy) begin
                n_words++;
                if (i_item.command == CMD_ANALYZE) begin
                    n_analyze++;
                    analyze_flows(i_item.hour_of_day);
                end else begin
                    flow_sample(i_item);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_HIGH_THR:   m_high_thr   = val;
            CFG_OFF_THR:    m_off_thr    = val;
            CFG_SEV_FULL:   m_sev_full   = val;
            CFG_CONF_FULL:  m_conf_full  = val;
            CFG_WORK_START: m_work_start = val[HOUR_W-1:0];
            CFG_WORK_END:   m_work_end   = val[HOUR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        do @(posedge i_clk);
        while (item_q.size() > 0 || start || anomaly_q.size() > 0 || busy);
        repeat (10) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic t_item sample_word(int f, logic [RATE_W-1:0] rate);
        t_item it;
        it = pool_t[f];
        it.command     = CMD_SAMPLE;
        it.bytes_rate  = rate;
        it.hour_of_day = HOUR_W'($urandom_range(31));
        return it;
    endfunction

    function automatic t_item analyze_word(logic [HOUR_W-1:0] hour);
        t_item it;
        it = pool_t[$urandom_range(POOL-1)];
        it.command     = CMD_ANALYZE;
        it.bytes_rate  = RATE_W'($urandom);
        it.hour_of_day = hour;
        return it;
    endfunction

    function automatic logic [RATE_W-1:0] flow_rate(int f);
        case (f % 5)
            0: return RATE_W'($urandom_range(9000000, 5500000));
            1: return ($urandom_range(9) == 0) ? RATE_W'($urandom_range(268435455, 50000000))
                                               : RATE_W'($urandom_range(5000, 1000));
            2: return RATE_W'($urandom_range(4000000, 2500000));
            3: return RATE_W'($urandom);
            default: return (f == POOL - 1) ? '0 : RATE_W'($urandom_range(400000));
        endcase
    endfunction

    task automatic random_traffic(int count, logic pause_mid);
        int f, r;
        for (int k = 0; k < count; k++) begin
            // pause the sender until all anomalies are back
            if (pause_mid && k == count / 2) wait_drain();
            if ($urandom_range(9) == 0) begin
                queue_word(analyze_word(HOUR_W'($urandom_range(31))));
            end else begin
                r = $urandom_range(99);
                f = (r < 60) ? $urandom_range(3) :
                    (r < 85) ? $urandom_range(11, 4) : $urandom_range(POOL - 1, 12);
                queue_word(sample_word(f, flow_rate(f)));
            end
        end
        queue_word(analyze_word(HOUR_W'($urandom_range(31))));
    endtask

    initial begin
        t_item it;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        errors = 0; cycles = 0; n_words = 0; n_analyze = 0; n_results = 0;
        foreach (kind_seen[i]) kind_seen[i] = 0;
        idle_pct = 27;
        m_high_thr = 28'd5242880; m_off_thr = 28'd2097152;
        m_sev_full = 28'd10485760; m_conf_full = 28'd20971520;
        m_work_start = 5'd8; m_work_end = 5'd18;
        for (int i = 0; i < FLOWS; i++) begin
            tbl_valid[i] = 1'b0; tbl_addr[i] = '0; tbl_ppp[i] = '0;
            tbl_cnt[i] = 0; tbl_wpos[i] = 0; tbl_sum[i] = 0; tbl_sqs[i] = 0;
            for (int j = 0; j < WINDOW; j++) tbl_win[i][j] = 0;
        end
        for (int i = 0; i < POOL; i++) begin
            pool_t[i].command  = CMD_SAMPLE;
            pool_t[i].src_addr = $urandom;
            pool_t[i].dst_addr = $urandom;
            pool_t[i].src_port = 16'($urandom);
            pool_t[i].dst_port = 16'($urandom);
            pool_t[i].protocol = 8'($urandom);
        end
        pool_t[POOL-2] = '0;
        pool_t[POOL-1] = '1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extreme tuples, steady and bursty flows, hour edges
        queue_word(analyze_word(5'd3));
        queue_word(sample_word(POOL - 2, '0));
        queue_word(sample_word(POOL - 2, '1));
        queue_word(sample_word(POOL - 1, '1));
        for (int i = 0; i < 6; i++) queue_word(sample_word(0, RATE_W'(7000000 + i)));
        for (int i = 0; i < 4; i++) queue_word(sample_word(1, RATE_W'(1000)));
        queue_word(sample_word(1, RATE_W'(200000000)));
        queue_word(analyze_word(5'd3));
        queue_word(analyze_word(5'd10));
        queue_word(analyze_word(5'd19));
        queue_word(analyze_word(5'd21));
        queue_word(analyze_word(5'd7));
        queue_word(analyze_word(5'd23));
        queue_word(analyze_word(5'd31));
        random_traffic(PHASE_N, 1'b1);
        wait_drain();

        // extremes: every nonzero rate counts as high, full-rate registers at zero and max
        idle_pct = 0;
        cfg_write(CFG_HIGH_THR, '0);
        cfg_write(CFG_OFF_THR, '0);
        cfg_write(CFG_SEV_FULL, '0);
        cfg_write(CFG_CONF_FULL, '1);
        cfg_write(CFG_WORK_START, 28'd0);
        cfg_write(CFG_WORK_END, 28'd23);
        cfg_write(3'd6, '1);
        cfg_write(3'd7, '1);
        idle_pct = 62;
        queue_word(analyze_word(5'd24));
        random_traffic(PHASE_N, 1'b0);
        wait_drain();

        idle_pct = 0;
        cfg_write(CFG_HIGH_THR, '1);
        cfg_write(CFG_OFF_THR, 28'd1000000);
        cfg_write(CFG_SEV_FULL, '1);
        cfg_write(CFG_CONF_FULL, '0);
        cfg_write(CFG_WORK_START, 28'd31);
        cfg_write(CFG_WORK_END, 28'd0);
        random_traffic(PHASE_N / 2, 1'b0);
        wait_drain();
        cfg_write(CFG_HIGH_THR, 28'd3000000);
        cfg_write(CFG_SEV_FULL, 28'd1);
        cfg_write(CFG_WORK_START, 28'($urandom_range(23)));
        cfg_write(CFG_WORK_END, 28'($urandom_range(23)));
        random_traffic(PHASE_N / 2, 1'b0);
        wait_drain();
        repeat (50) @(posedge i_clk);

        $display("Covered %0d words (%0d analyze runs) over three register settings,",
                 n_words, n_analyze);
        $display("%0d results: none %0d, exfiltration %0d, volatility %0d, off-hours %0d",
                 n_results, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        if (errors == 0 && anomaly_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, anomaly_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### flow_rate_window_anomaly_detector.f
src/frwad_pkg.sv
src/frwad_ram.sv
src/flow_rate_window_anomaly_detector.sv
dv/tb_flow_rate_window_anomaly_detector.sv
